/* hw/rtl/jsd_pkg.sv */
// ----------------------------------------------------------------------------
// JEF stitch decoder package
// Shared constants and types of the stitch stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jsd_pkg;

	localparam int unsigned COUNT_W = 25;

	localparam logic [7:0] ESCAPE_BYTE = 8'h80;
	localparam logic [7:0] END_CODE    = 8'h10;
	localparam logic [7:0] TRIM_CODE_A = 8'h02;
	localparam logic [7:0] TRIM_CODE_B = 8'h04;
	localparam logic [7:0] TRIM_CODE_C = 8'h06;

	localparam logic [COUNT_W-1:0] LIMIT_RESET = 25'd16777315;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

	localparam logic [1:0] KIND_NORMAL = 2'd0;
	localparam logic [1:0] KIND_STOP   = 2'd1;
	localparam logic [1:0] KIND_TRIM   = 2'd2;
	localparam logic [1:0] KIND_END    = 2'd3;

	localparam logic [1:0] PH_FIRST      = 2'd0;
	localparam logic [1:0] PH_SECOND     = 2'd1;
	localparam logic [1:0] PH_RAW_FIRST  = 2'd2;
	localparam logic [1:0] PH_RAW_SECOND = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_start;
	} byte_item_t;

	typedef struct packed {
		logic signed [7:0] step_x;
		logic signed [7:0] step_y;
		logic [1:0]        record_kind;
	} record_t;

endpackage

`default_nettype wire

/* hw/rtl/jsd_byte_if.sv */
// ----------------------------------------------------------------------------
// Byte channel
// Valid/ready channel that carries one raw byte of the stitch area per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_start;

	modport source (output valid, output data_byte, output stream_start, input ready);
	modport sink (input valid, input data_byte, input stream_start, output ready);
endinterface

`default_nettype wire

/* hw/rtl/jsd_record_if.sv */
// ----------------------------------------------------------------------------
// Record channel
// Valid/ready channel that carries one decoded stitch record per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsd_record_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] step_x;
	logic signed [7:0] step_y;
	logic [1:0]        record_kind;

	modport source (output valid, output step_x, output step_y, output record_kind,
		input ready);
	modport sink (input valid, input step_x, input step_y, input record_kind,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/jsd_stitch_core_top.sv */
// ----------------------------------------------------------------------------
// JEF stitch stream decoder core
// Pairs raw stitch-area bytes into normal, stop, trim and end records.
// ----------------------------------------------------------------------------
//   channel        dir   word
//   bytes          in    data_byte, stream_start
//   records        out   step_x, step_y, record_kind
//   record_limit   in    write enable and 25-bit write data
//
// One byte is accepted per cycle unless the byte channel stalls; the byte that
// completes a record passes the byte register and then the record register.
// Reset clears the pairing state, the record count and the finished flag, and
// loads the record limit with 16777315.
// A stalled record register holds the byte register, and the byte channel
// stalls only when both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module jef_stitch_stream_decoder_core
	import jsd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	jsd_byte_if.sink                bytes,
	jsd_record_if.source            records,
	input  wire logic               record_limit_we,
	input  wire logic [COUNT_W-1:0] record_limit_wdata
);

	logic [COUNT_W-1:0] limit_q;
	logic               valid_s1;
	byte_item_t         item_s1;
	logic               out_valid_q;
	record_t            out_rec_q;
	logic               advance;
	logic               emit;
	record_t            rec;

	assign advance     = valid_s1 && (!out_valid_q || records.ready);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (record_limit_we) begin
			limit_q <= record_limit_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1.data_byte    <= bytes.data_byte;
			item_s1.stream_start <= bytes.stream_start;
		end
	end

	jsd_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item         (item_s1),
		.record_limit (limit_q),
		.emit         (emit),
		.rec          (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (records.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_rec_q <= rec;
		end
	end

	assign records.valid       = out_valid_q;
	assign records.step_x      = out_rec_q.step_x;
	assign records.step_y      = out_rec_q.step_y;
	assign records.record_kind = out_rec_q.record_kind;

`ifndef SYNTHESIS
	a_end_has_zero_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_rec_q.record_kind == KIND_END) |->
		(out_rec_q.step_x == 8'sd0 && out_rec_q.step_y == 8'sd0))
		else $error("end record with nonzero steps");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!bytes.ready |-> (valid_s1 && out_valid_q && !records.ready))
		else $error("byte channel stalled with room in the pipeline");

	a_record_from_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && emit))
		else $error("record appeared without a decoded byte");
`endif

endmodule

`default_nettype wire

/* hw/rtl/jsd_decode.sv */
// ----------------------------------------------------------------------------
// Stitch pair decoder
// Holds the pairing state and turns one registered byte into at most one record.
// ----------------------------------------------------------------------------
`default_nettype none

module jsd_decode
	import jsd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire byte_item_t         item,
	input  wire logic [COUNT_W-1:0] record_limit,
	output logic                    emit,
	output record_t                 rec
);

	logic [1:0]         phase_q, phase_e, phase_d;
	logic [7:0]         held_q, held_e, held_d;
	logic [1:0]         pend_q, pend_e, pend_d;
	logic [COUNT_W-1:0] count_q, count_e, count_d;
	logic               fin_q, fin_e, fin_d;
	logic               is_esc;
	logic               is_trim;

	always_comb begin
		if (item.stream_start) begin
			phase_e = PH_FIRST;
			held_e  = 8'd0;
			pend_e  = KIND_NORMAL;
			count_e = '0;
			fin_e   = 1'b0;
		end else begin
			phase_e = phase_q;
			held_e  = held_q;
			pend_e  = pend_q;
			count_e = count_q;
			fin_e   = fin_q;
		end
	end

	assign is_esc  = (held_e == ESCAPE_BYTE);
	assign is_trim = (item.data_byte == TRIM_CODE_A) || (item.data_byte == TRIM_CODE_B)
		|| (item.data_byte == TRIM_CODE_C);

	always_comb begin
		phase_d = phase_e;
		held_d  = held_e;
		pend_d  = pend_e;
		fin_d   = fin_e;
		emit    = 1'b0;
		rec.step_x      = $signed(held_e);
		rec.step_y      = $signed(item.data_byte);
		rec.record_kind = KIND_NORMAL;
		if (!fin_e) begin
			case (phase_e)
				PH_FIRST: begin
					if (count_e < record_limit) begin
						held_d  = item.data_byte;
						phase_d = PH_SECOND;
					end
				end
				PH_SECOND: begin
					phase_d = PH_FIRST;
					if (is_esc && item.data_byte[0]) begin
						pend_d  = KIND_STOP;
						phase_d = PH_RAW_FIRST;
					end else if (is_esc && is_trim) begin
						pend_d  = KIND_TRIM;
						phase_d = PH_RAW_FIRST;
					end else if (is_esc && (item.data_byte == END_CODE)) begin
						fin_d           = 1'b1;
						emit            = 1'b1;
						rec.step_x      = 8'sd0;
						rec.step_y      = 8'sd0;
						rec.record_kind = KIND_END;
					end else begin
						emit = 1'b1;
					end
				end
				PH_RAW_FIRST: begin
					held_d  = item.data_byte;
					phase_d = PH_RAW_SECOND;
				end
				default: begin
					phase_d         = PH_FIRST;
					pend_d          = KIND_NORMAL;
					emit            = 1'b1;
					rec.record_kind = pend_e;
				end
			endcase
		end
		count_d = (emit && (count_e != COUNT_MAX)) ? count_e + 1'b1 : count_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			held_q  <= 8'd0;
			pend_q  <= KIND_NORMAL;
			count_q <= '0;
			fin_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			pend_q  <= pend_d;
			count_q <= count_d;
			fin_q   <= fin_d;
		end
	end

`ifndef SYNTHESIS
	a_no_emit_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_q && !item.stream_start) |-> !emit)
		else $error("record produced after the end record");

	a_raw_kind_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RAW_FIRST || phase_q == PH_RAW_SECOND) |->
		(pend_q == KIND_STOP || pend_q == KIND_TRIM))
		else $error("raw pair in progress without a stop or trim kind");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !item.stream_start && count_q == COUNT_MAX) |=> count_q == COUNT_MAX)
		else $error("record count wrapped");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stitch stream decoder testbench
// Drives raw stitch-area bytes into the decoder core and checks every record
// against a cycle-free decoder written here or a record fixed in the script.
// Directed bytes go first, then random stitch, stop, trim and end sequences
// under several record limits and with random idling on both channels.
// ----------------------------------------------------------------------------

module testbench;
	import jsd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct {
		logic [7:0] data_byte;
		logic       stream_start;
		bit         fixed;
		record_t    rec;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic record_limit_we = 1'b0;
	logic [COUNT_W-1:0] record_limit_wdata = '0;

	jsd_byte_if byte_ch ();
	jsd_record_if record_ch ();

	jef_stitch_stream_decoder_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(byte_ch),
		.records(record_ch),
		.record_limit_we(record_limit_we),
		.record_limit_wdata(record_limit_wdata)
	);

	// Decoder state kept by the testbench.
	logic [1:0] pair_step = PH_FIRST;
	logic [7:0] first_byte = '0;
	logic [1:0] raw_kind = KIND_NORMAL;
	logic [COUNT_W-1:0] records_made = '0;
	bit design_done = 1'b0;
	logic [COUNT_W-1:0] limit_shadow = LIMIT_RESET;

	record_t expected_records[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_idle_pct = 0;
	bit hold_request = 1'b0;
	bit restart_next = 1'b0;
	bit cur_fixed = 1'b0;
	record_t cur_rec = '0;
	script_row_t script [23];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit decode_byte(input logic [7:0] b, input logic start,
		output record_t rec);
		bit made;
		made = 1'b0;
		rec = '0;
		if (start) begin
			pair_step = PH_FIRST;
			first_byte = '0;
			raw_kind = KIND_NORMAL;
			records_made = '0;
			design_done = 1'b0;
		end
		if (design_done)
			return 1'b0;
		case (pair_step)
			PH_FIRST: begin
				if (records_made >= limit_shadow)
					return 1'b0;
				first_byte = b;
				pair_step = PH_SECOND;
			end
			PH_SECOND: begin
				pair_step = PH_FIRST;
				made = 1'b1;
				rec.step_x = first_byte;
				rec.step_y = b;
				rec.record_kind = KIND_NORMAL;
				if (first_byte == ESCAPE_BYTE) begin
					if (b[0]) begin
						raw_kind = KIND_STOP;
						pair_step = PH_RAW_FIRST;
						made = 1'b0;
					end else if (b == TRIM_CODE_A || b == TRIM_CODE_B || b == TRIM_CODE_C) begin
						raw_kind = KIND_TRIM;
						pair_step = PH_RAW_FIRST;
						made = 1'b0;
					end else if (b == END_CODE) begin
						design_done = 1'b1;
						rec.step_x = '0;
						rec.step_y = '0;
						rec.record_kind = KIND_END;
					end
				end
			end
			PH_RAW_FIRST: begin
				first_byte = b;
				pair_step = PH_RAW_SECOND;
			end
			default: begin
				pair_step = PH_FIRST;
				made = 1'b1;
				rec.step_x = first_byte;
				rec.step_y = b;
				rec.record_kind = raw_kind;
				raw_kind = KIND_NORMAL;
			end
		endcase
		if (made && records_made != COUNT_MAX)
			records_made = records_made + 1'b1;
		return made;
	endfunction

	always @(posedge clk) begin
		record_t predicted;
		record_t exp_rec;
		bit made;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else if (arst_n) begin
			if (record_limit_we)
				limit_shadow = record_limit_wdata;
			if (byte_ch.valid && byte_ch.ready) begin
				made = decode_byte(byte_ch.data_byte, byte_ch.stream_start, predicted);
				if (cur_fixed)
					expected_records.push_back(cur_rec);
				else if (made)
					expected_records.push_back(predicted);
			end
			if (record_ch.valid && record_ch.ready) begin
				if (expected_records.size() == 0) begin
					$error("record with no expectation: x %0d y %0d kind %0d",
						record_ch.step_x, record_ch.step_y, record_ch.record_kind);
					mismatch_count++;
				end else begin
					exp_rec = expected_records.pop_front();
					if (record_ch.step_x !== exp_rec.step_x) begin
						$error("step_x expected %0d got %0d", exp_rec.step_x, record_ch.step_x);
						mismatch_count++;
					end
					if (record_ch.step_y !== exp_rec.step_y) begin
						$error("step_y expected %0d got %0d", exp_rec.step_y, record_ch.step_y);
						mismatch_count++;
					end
					if (record_ch.record_kind !== exp_rec.record_kind) begin
						$error("record_kind expected %0d got %0d", exp_rec.record_kind,
							record_ch.record_kind);
						mismatch_count++;
					end
				end
			end
		end
	end

	// The receiver can be told to refuse records for a long stretch so that
	// the core fills up and stalls the byte channel.
	initial begin
		record_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				record_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			record_ch.ready = ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic start, input bit fixed,
		input record_t rec);
		while ($urandom_range(99) < sender_idle_pct) begin
			byte_ch.valid = 1'b0;
			@(negedge clk);
		end
		byte_ch.valid = 1'b1;
		byte_ch.data_byte = b;
		byte_ch.stream_start = start;
		cur_fixed = fixed;
		cur_rec = rec;
		do
			@(posedge clk);
		while (!byte_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_next_byte(input logic [7:0] b);
		send_byte(b, restart_next, 1'b0, '0);
		restart_next = 1'b0;
	endtask

	task automatic write_limit(input logic [COUNT_W-1:0] value);
		byte_ch.valid = 1'b0;
		while (expected_records.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		record_limit_we = 1'b1;
		record_limit_wdata = value;
		@(negedge clk);
		record_limit_we = 1'b0;
	endtask

	task automatic send_raw_pair();
		if ($urandom_range(3) == 0)
			send_next_byte(ESCAPE_BYTE);
		else
			send_next_byte(8'($urandom_range(255)));
		send_next_byte(8'($urandom_range(255)));
	endtask

	// Mostly well-formed stitch sequences, with stray bytes and restarts mixed in.
	task automatic send_stream(input int unsigned n_bytes, input int unsigned restart_pct);
		int unsigned sent;
		int unsigned pick;
		logic [7:0] code;
		sent = 0;
		while (sent < n_bytes) begin
			if ($urandom_range(99) < restart_pct)
				restart_next = 1'b1;
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_next_byte(8'($urandom_range(255)));
				send_next_byte(8'($urandom_range(255)));
				sent += 2;
			end else if (pick < 82) begin
				send_next_byte(ESCAPE_BYTE);
				if (pick < 70) begin
					code = {7'($urandom_range(127)), 1'b1};
				end else begin
					case ($urandom_range(2))
						0: code = TRIM_CODE_A;
						1: code = TRIM_CODE_B;
						default: code = TRIM_CODE_C;
					endcase
				end
				send_next_byte(code);
				send_raw_pair();
				sent += 4;
			end else if (pick < 87) begin
				do
					code = {7'($urandom_range(127)), 1'b0};
				while (code == TRIM_CODE_A || code == TRIM_CODE_B || code == TRIM_CODE_C
					|| code == END_CODE);
				send_next_byte(ESCAPE_BYTE);
				send_next_byte(code);
				sent += 2;
			end else if (pick < 90) begin
				send_next_byte(ESCAPE_BYTE);
				send_next_byte(END_CODE);
				sent += 2;
				repeat ($urandom_range(3))
					send_next_byte(8'($urandom_range(255)));
				restart_next = 1'b1;
			end else if (pick < 95) begin
				send_next_byte(8'($urandom_range(255)));
				sent += 1;
			end else begin
				restart_next = 1'b1;
			end
		end
	endtask

	initial begin
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.stream_start = 1'b0;
		script = '{
			'{8'h00, 1'b1, 1'b0, '0},
			'{8'h00, 1'b0, 1'b1, '{8'h00, 8'h00, KIND_NORMAL}},
			'{8'h7F, 1'b0, 1'b0, '0},
			'{8'h80, 1'b0, 1'b1, '{8'h7F, 8'h80, KIND_NORMAL}},
			'{8'h80, 1'b0, 1'b0, '0},
			'{8'h01, 1'b0, 1'b0, '0},
			'{8'h80, 1'b0, 1'b0, '0},
			'{8'h10, 1'b0, 1'b1, '{8'h80, 8'h10, KIND_STOP}},
			'{8'h80, 1'b0, 1'b0, '0},
			'{8'h02, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'h01, 1'b0, 1'b0, '0},
			'{8'h80, 1'b0, 1'b0, '0},
			'{8'h08, 1'b0, 1'b0, '0},
			'{8'h80, 1'b0, 1'b0, '0},
			'{8'h10, 1'b0, 1'b1, '{8'h00, 8'h00, KIND_END}},
			'{8'h55, 1'b0, 1'b0, '0},
			'{8'h80, 1'b1, 1'b0, '0},
			'{8'hFE, 1'b0, 1'b0, '0},
			'{8'h80, 1'b0, 1'b0, '0},
			'{8'h06, 1'b0, 1'b0, '0},
			'{8'hAA, 1'b0, 1'b0, '0},
			'{8'h55, 1'b0, 1'b0, '0}
		};
		sender_idle_pct = 25;
		receiver_idle_pct = 84;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script[i])
			send_byte(script[i].data_byte, script[i].stream_start, script[i].fixed,
				script[i].rec);

		write_limit('0);
		restart_next = 1'b1;
		repeat (4)
			send_next_byte(8'($urandom_range(255)));

		write_limit(LIMIT_RESET);
		hold_request = 1'b1;
		send_stream(300, 3);

		sender_idle_pct = 84;
		receiver_idle_pct = 25;
		write_limit(COUNT_W'($urandom_range(12, 2)));
		restart_next = 1'b1;
		send_stream(300, 12);

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		write_limit(COUNT_W'(1));
		restart_next = 1'b1;
		send_stream(150, 35);

		write_limit(COUNT_W'($urandom_range(32'(LIMIT_RESET), 1000)));
		restart_next = 1'b1;
		send_stream(150, 5);

		byte_ch.valid = 1'b0;
		while (expected_records.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/jsd_pkg.sv
hw/rtl/jsd_byte_if.sv
hw/rtl/jsd_record_if.sv
hw/rtl/jsd_decode.sv
hw/rtl/jsd_stitch_core_top.sv
tb/testbench.sv
